[src/bcem_pkg.sv]
// Shared constants and types for the block chain extent mapper.
package bcem_pkg;

  localparam int unsigned BCEM_DEPOT_ENTRIES = 4096;
  localparam int unsigned BCEM_BLOCK_SIZE    = 512;
  localparam int unsigned BCEM_MAX_CHARS     = 16128;
  localparam int unsigned MAX_RESULTS        = 64;

  localparam int unsigned DEPOT_W     = 14;
  localparam int unsigned USED_W      = 13;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [DEPOT_W-1:0] CHAIN_END = 14'h3FFE;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_MAP   = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_CORRUPT = 2'd2
  } status_t;

endpackage

[src/bcem_depot.sv]
// Depot of next-block links: one write port, one read port, registered read data.
module bcem_depot #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [bcem_pkg::DEPOT_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [bcem_pkg::DEPOT_W-1:0] rd_data
);
  import bcem_pkg::*;

  logic [DEPOT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/block_chain_extent_mapper_unit.sv]
// Top level of the block chain extent mapper: request handling, chain walk and result register.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid / tready   tuser kind; tdata write entry or map request
//  m_*      out  tvalid / tready   tdata extent; tuser status; tlast end of request
//  cfg_*    in   write enable      depot_used
//
// A write item is taken while idle and leaves the state as it is. A map request is accepted
// from idle, visits each chain link through the walk and fetch states (the registered depot
// read sets the pair), then closes: the walk sees its end, finish hands over the last items.
// Reset clears the control state and depot_used; the depot contents are undefined until written.
// A full result register that is not being taken holds the walk where it stands.
module block_chain_extent_mapper_unit #(
  parameter int unsigned DEPOT_ENTRIES = bcem_pkg::BCEM_DEPOT_ENTRIES,
  parameter int unsigned MAX_CHARS     = bcem_pkg::BCEM_MAX_CHARS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index[11:0], entry_value[25:12], first_offset[46:26], char_count[60:47],
  // uses_unicode[61], start_block[73:62], zero fill above
  input  logic [bcem_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // file_offset[21:0], text_offset[43:22], extent_length[53:44], extent_unicode[54], zero fill
  output logic [bcem_pkg::OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [bcem_pkg::STATUS_W-1:0]   m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [bcem_pkg::USED_W-1:0]     cfg_wdata
);
  import bcem_pkg::*;

  // The extent length field is sized for this block size.
  localparam int unsigned BLOCK_SIZE = BCEM_BLOCK_SIZE;

  localparam int unsigned AW    = $clog2(DEPOT_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);
  localparam logic [16:0] ENTRIES_W = 17'(DEPOT_ENTRIES);
  localparam logic [16:0] MAXC_W    = 17'(MAX_CHARS);
  localparam logic [21:0] BS22      = 22'(BLOCK_SIZE);
  localparam logic [20:0] BS21      = 21'(BLOCK_SIZE);
  localparam logic [CNT_W-1:0] RES_LIMIT = CNT_W'(MAX_RESULTS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;

  // Request fields
  logic [11:0] in_entry_index;
  logic [13:0] in_entry_value;
  logic [20:0] in_first_offset;
  logic [13:0] in_char_count;
  logic        in_uses_unicode;
  logic [11:0] in_start_block;

  assign in_entry_index  = s_tdata[11:0];
  assign in_entry_value  = s_tdata[25:12];
  assign in_first_offset = s_tdata[46:26];
  assign in_char_count   = s_tdata[60:47];
  assign in_uses_unicode = s_tdata[61];
  assign in_start_block  = s_tdata[73:62];

  // Walk state
  logic [USED_W-1:0]  depot_used;
  logic [DEPOT_W-1:0] cur_blk;
  logic [20:0]        skip_offset;
  logic [14:0]        bytes_to_go;
  logic [21:0]        text_position;
  logic [USED_W-1:0]  walk_steps;
  logic [CNT_W-1:0]   ext_count;
  logic               uni;
  status_t            end_status;

  // Extent held back until it is known whether it closes the request
  logic        pend_valid;
  logic [21:0] pend_file;
  logic [21:0] pend_text;
  logic [9:0]  pend_len;

  // Result register
  logic        out_valid;
  logic [21:0] out_file;
  logic [21:0] out_text;
  logic [9:0]  out_len;
  logic        out_uni;
  logic        out_last;
  status_t     out_status;

  logic               accept;
  logic               out_free;
  logic [16:0]        cur_ext;
  logic [16:0]        limit;
  logic               done_walk;
  logic               corrupt;
  logic               skipping;
  logic [21:0]        len22;
  logic [21:0]        file22;
  logic [16:0]        chars;
  logic [16:0]        idx_ext;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [DEPOT_W-1:0] mem_rdata;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_uni, out_len, out_text, out_file};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  always_comb begin
    idx_ext   = 17'(in_entry_index);
    mem_we    = accept && (kind_t'(s_tuser) == KIND_WRITE) && (idx_ext < ENTRIES_W);
    mem_waddr = idx_ext[AW-1:0];

    cur_ext   = {3'b000, cur_blk};
    mem_raddr = cur_ext[AW-1:0];
    limit     = ({4'b0000, depot_used} < ENTRIES_W) ? {4'b0000, depot_used} : ENTRIES_W;

    done_walk = (cur_blk == CHAIN_END) || (bytes_to_go == '0);
    corrupt   = cur_blk[DEPOT_W-1] || (cur_ext >= limit) || (walk_steps >= depot_used);
    skipping  = (skip_offset >= BS21);

    len22 = BS22 - {1'b0, skip_offset};
    if (len22 > {7'b0000000, bytes_to_go}) begin
      len22 = {7'b0000000, bytes_to_go};
    end
    file22 = 22'((32'(cur_ext) + 32'd1) * 32'(BLOCK_SIZE)) + {1'b0, skip_offset};

    chars = ({3'b000, in_char_count} > MAXC_W) ? MAXC_W : {3'b000, in_char_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depot_used <= '0;
    end else if (cfg_we) begin
      depot_used <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      cur_blk       <= '0;
      skip_offset   <= '0;
      bytes_to_go   <= '0;
      text_position <= '0;
      walk_steps    <= '0;
      ext_count     <= '0;
      uni           <= 1'b0;
      end_status    <= STAT_OK;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (kind_t'(s_tuser) == KIND_MAP)) begin
            uni           <= in_uses_unicode;
            bytes_to_go   <= in_uses_unicode ? 15'({chars, 1'b0}) : 15'(chars);
            skip_offset   <= in_first_offset;
            text_position <= {1'b0, in_first_offset};
            cur_blk       <= {2'b00, in_start_block};
            walk_steps    <= '0;
            ext_count     <= '0;
            pend_valid    <= 1'b0;
            state         <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (done_walk) begin
            end_status <= (bytes_to_go != '0) ? STAT_SHORT : STAT_OK;
            state      <= ST_FINISH;
          end else if (corrupt) begin
            end_status <= STAT_CORRUPT;
            state      <= ST_FINISH;
          end else if (skipping) begin
            walk_steps  <= walk_steps + 1'b1;
            skip_offset <= skip_offset - BS21;
            state       <= ST_FETCH;
          end else if (ext_count >= RES_LIMIT) begin
            // Out of result slots: the held extent closes the request as short.
            end_status <= STAT_SHORT;
            state      <= ST_FINISH;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid  <= 1'b1;
              out_file   <= pend_file;
              out_text   <= pend_text;
              out_len    <= pend_len;
              out_uni    <= uni;
              out_last   <= 1'b0;
              out_status <= STAT_OK;
            end
            pend_valid    <= 1'b1;
            pend_file     <= file22;
            pend_text     <= text_position;
            pend_len      <= len22[9:0];
            ext_count     <= ext_count + 1'b1;
            walk_steps    <= walk_steps + 1'b1;
            skip_offset   <= '0;
            text_position <= text_position + len22;
            bytes_to_go   <= bytes_to_go - len22[14:0];
            state         <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          cur_blk <= mem_rdata;
          state   <= ST_WALK;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_uni   <= uni;
            if (end_status == STAT_OK && pend_valid) begin
              out_file   <= pend_file;
              out_text   <= pend_text;
              out_len    <= pend_len;
              out_last   <= 1'b1;
              out_status <= STAT_OK;
              pend_valid <= 1'b0;
              state      <= ST_IDLE;
            end else if (ext_count < RES_LIMIT) begin
              if (pend_valid) begin
                out_file   <= pend_file;
                out_text   <= pend_text;
                out_len    <= pend_len;
                out_last   <= 1'b0;
                out_status <= STAT_OK;
                pend_valid <= 1'b0;
              end else begin
                // Closing item with no extent of its own.
                out_file   <= '0;
                out_text   <= text_position;
                out_len    <= '0;
                out_last   <= 1'b1;
                out_status <= end_status;
                state      <= ST_IDLE;
              end
            end else begin
              out_file   <= pend_file;
              out_text   <= pend_text;
              out_len    <= pend_len;
              out_last   <= 1'b1;
              out_status <= end_status;
              pend_valid <= 1'b0;
              state      <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bcem_depot #(
    .DEPTH (DEPOT_ENTRIES)
  ) u_depot (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_entry_value),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // A depot read is only consumed in the cycle after the walk issued it.
  a_fetch_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> $past(state) == ST_WALK)
    else $error("fetch state entered without a preceding walk step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ext_count <= RES_LIMIT)
    else $error("extent count passed the result limit");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("held extent left behind when the request closed");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> m_tlast)
    else $error("non-ok status on an item that does not close the request");

  a_result_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) != ST_IDLE)
    else $error("result produced while no request was being mapped");

endmodule

[verif/bcem_extent_checker.sv]
// Checker for the block chain extent mapper: predicts extents from accepted items and compares.
module bcem_extent_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [bcem_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [bcem_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [bcem_pkg::STATUS_W-1:0]   m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [bcem_pkg::USED_W-1:0]     cfg_wdata,
  output int                              errors,
  output int                              pending,
  output int                              checked
);
  import bcem_pkg::*;

  localparam int END_MARK = $signed(CHAIN_END);

  typedef struct packed {
    logic [21:0] file_offset;
    logic [21:0] text_offset;
    logic [9:0]  byte_count;
    logic        unicode;
    logic        last;
    status_t     status;
  } extent_t;

  logic [DEPOT_W-1:0] link_table [BCEM_DEPOT_ENTRIES];
  logic [USED_W-1:0]  used_count;
  extent_t            expected_extents [$];

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("checker: %s", msg);
    errors++;
  endtask

  // Follows the chain as the block does and queues every extent that one map request yields.
  function automatic void map_extents(input logic [20:0] offset, input logic [13:0] chars_in,
                                      input logic uni, input logic [11:0] start);
    int      chars, bytes_left, skip, tpos, steps, lim, blk, len, cur;
    bit      capped;
    status_t st;
    extent_t ext;
    extent_t batch [$];
    chars = chars_in;
    if (chars > BCEM_MAX_CHARS) chars = BCEM_MAX_CHARS;
    bytes_left = uni ? 2 * chars : chars;
    skip = offset;
    tpos = offset;
    cur = start;
    steps = 0;
    lim = (used_count < BCEM_DEPOT_ENTRIES) ? int'(used_count) : BCEM_DEPOT_ENTRIES;
    st = STAT_OK;
    capped = 1'b0;
    while (cur != END_MARK && bytes_left != 0) begin
      if (cur < 0 || cur >= lim || steps >= int'(used_count)) begin
        st = STAT_CORRUPT;
        break;
      end
      steps++;
      blk = cur;
      if (skip >= BCEM_BLOCK_SIZE) begin
        skip -= BCEM_BLOCK_SIZE;
      end else begin
        if (batch.size() >= MAX_RESULTS) begin
          capped = 1'b1;
          break;
        end
        len = BCEM_BLOCK_SIZE - skip;
        if (len > bytes_left) len = bytes_left;
        ext.file_offset = 22'((blk + 1) * BCEM_BLOCK_SIZE + skip);
        ext.text_offset = 22'(tpos);
        ext.byte_count  = 10'(len);
        ext.unicode     = uni;
        ext.last        = 1'b0;
        ext.status      = STAT_OK;
        batch.push_back(ext);
        skip = 0;
        tpos += len;
        bytes_left -= len;
      end
      cur = $signed(link_table[blk]);
    end

    if (capped) begin
      // Out of result slots with the walk unfinished: the final extent closes as short.
      ext = batch.pop_back();
      ext.last = 1'b1;
      ext.status = STAT_SHORT;
      batch.push_back(ext);
    end else begin
      if (st == STAT_OK && bytes_left != 0) st = STAT_SHORT;
      if (st == STAT_OK && batch.size() > 0) begin
        ext = batch.pop_back();
        ext.last = 1'b1;
        batch.push_back(ext);
      end else if (batch.size() < MAX_RESULTS) begin
        ext.file_offset = '0;
        ext.text_offset = 22'(tpos);
        ext.byte_count  = '0;
        ext.unicode     = uni;
        ext.last        = 1'b1;
        ext.status      = st;
        batch.push_back(ext);
      end else begin
        ext = batch.pop_back();
        ext.last = 1'b1;
        ext.status = st;
        batch.push_back(ext);
      end
    end
    foreach (batch[i]) expected_extents.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin
    extent_t got, want;
    string   diff;
    if (rst) begin
      used_count = '0;
      expected_extents.delete();
      pending <= 0;
    end else begin
      if (cfg_we) used_count = cfg_wdata;
      if (s_tvalid && s_tready) begin
        if (s_tuser == KIND_WRITE) begin
          link_table[s_tdata[11:0]] = s_tdata[25:12];
        end else begin
          map_extents(s_tdata[46:26], s_tdata[60:47], s_tdata[61], s_tdata[73:62]);
        end
      end
      if (m_tvalid && m_tready) begin
        got.file_offset = m_tdata[21:0];
        got.text_offset = m_tdata[43:22];
        got.byte_count  = m_tdata[53:44];
        got.unicode     = m_tdata[54];
        got.last        = m_tlast;
        got.status      = status_t'(m_tuser);
        if (expected_extents.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
        end else begin
          want = expected_extents.pop_front();
          diff = "";
          if (got.file_offset !== want.file_offset)
            diff = {diff, $sformatf(" file_offset %0d want %0d", got.file_offset,
                                    want.file_offset)};
          if (got.text_offset !== want.text_offset)
            diff = {diff, $sformatf(" text_offset %0d want %0d", got.text_offset,
                                    want.text_offset)};
          if (got.byte_count !== want.byte_count)
            diff = {diff, $sformatf(" length %0d want %0d", got.byte_count, want.byte_count)};
          if (got.unicode !== want.unicode)
            diff = {diff, $sformatf(" unicode %0b want %0b", got.unicode, want.unicode)};
          if (got.last !== want.last)
            diff = {diff, $sformatf(" last %0b want %0b", got.last, want.last)};
          if (got.status !== want.status)
            diff = {diff, $sformatf(" status %0d want %0d", got.status, want.status)};
          if (diff != "") report_mismatch($sformatf("result %0d:%s", checked, diff));
        end
        checked++;
      end
      pending <= expected_extents.size();
    end
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the block chain extent mapper: clock, reset, stimulus and verdict.
module tb_top;
  import bcem_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PRESSURE_HOLD  = 400;
  localparam int LINK_END       = $signed(CHAIN_END);

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [USED_W-1:0]     cfg_wdata;

  int errors, pending, checked;
  int items_sent, maps_sent, settings_done, burst_left, used_now, quiet_cycles;

  // Which depot entries hold a value; only those may ever be followed by a walk.
  bit written [BCEM_DEPOT_ENTRIES];
  int written_list [$];
  int heads [$];
  int head_len [$];

  always #10 clk = ~clk;

  block_chain_extent_mapper_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bcem_extent_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // Unused fields of each item carry random noise that the block must ignore.
  function automatic logic [IN_DATA_W-1:0] write_item(input int idx, input int val);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[73:26] = {16'($urandom()), $urandom()};
    d[11:0] = idx[11:0];
    d[25:12] = val[13:0];
    return d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] map_item(input int start, input int off,
                                                    input int chars, input int uni);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[25:0] = 26'($urandom());
    d[46:26] = off[20:0];
    d[60:47] = chars[13:0];
    d[61] = uni[0];
    d[73:62] = start[11:0];
    return d;
  endfunction

  task automatic push_item(input kind_t k, input logic [IN_DATA_W-1:0] d);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  task automatic write_link(input int idx, input int val);
    push_item(KIND_WRITE, write_item(idx, val));
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic map_range(input int start, input int off, input int chars, input int uni);
    push_item(KIND_MAP, map_item(start, off, chars, uni));
    maps_sent++;
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic drain();
    if (burst_left != 0) s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_depot_used(input int v);
    drain();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    used_now = v;
    settings_done++;
  endtask

  // Lays a chain of n links over blocks below depot_used (below 64 while it is zero) and records its head.
  task automatic build_chain(input int n);
    bit taken [BCEM_DEPOT_ENTRIES];
    int nodes [$];
    int span, k, pick, tries, tail;
    span = (used_now == 0) ? 64 : used_now;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, span - 1);
      tries = 0;
      while (taken[pick] && tries < 8) begin
        pick = $urandom_range(0, span - 1);
        tries++;
      end
      taken[pick] = 1'b1;
      nodes.push_back(pick);
    end
    for (k = 0; k < n - 1; k++) write_link(nodes[k], nodes[k + 1]);
    // Tails that point anywhere stay safe: negatives, links beyond any depot, written blocks.
    k = $urandom_range(0, 99);
    if (k < 65) begin
      tail = LINK_END;
    end else if (k < 75) begin
      case ($urandom_range(0, 2))
        0: tail = -1;
        1: tail = -3;
        default: tail = -4;
      endcase
    end else if (k < 85) begin
      tail = $urandom_range(BCEM_DEPOT_ENTRIES, 8191);
    end else begin
      tail = written_list[$urandom_range(0, written_list.size() - 1)];
    end
    write_link(nodes[n - 1], tail);
    heads.push_back(nodes[0]);
    head_len.push_back(n);
  endtask

  // Receiver: stall patterns in segments, and one long hold-off while items keep coming.
  initial begin
    int seg, mode, k;
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && items_sent >= 120 && s_tvalid) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 120);
      for (k = 0; k < seg; k++) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ((k % 4) < 2);
          default: m_tready <= ($urandom_range(0, 1) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: no item moved for %0d cycles", quiet_cycles);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int used_plan [9];
    int p, v, phase_start, n, h, r, start, blocks, off, chars, uni, lim;
    used_plan = '{16, 4096, 1, 0, 64, 300, -1, 4096, 40};
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= KIND_WRITE;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    burst_left = 0;
    used_now = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // With depot_used still at its reset value every block is out of range.
    map_range(0, 0, 5, 0);
    set_depot_used(BCEM_DEPOT_ENTRIES);
    write_link(4095, LINK_END);
    write_link(0, 1);
    write_link(1, 2);
    write_link(2, LINK_END);
    write_link(3, 8191);
    write_link(4, -4);
    write_link(5, -1);
    write_link(6, -3);
    write_link(7, 8);
    write_link(8, 7);
    map_range(0, 0, 0, 0);             // empty request
    map_range(0, 0, 100, 0);
    map_range(0, 300, 400, 1);         // spans three blocks
    map_range(0, 1024, 600, 0);        // chain runs out
    map_range(0, 2097151, 16383, 1);   // count saturates, skip beyond the chain
    map_range(3, 0, 1000, 0);          // link beyond the depot
    map_range(4, 0, 600, 0);
    map_range(5, 0, 600, 1);
    map_range(6, 100, 700, 0);
    map_range(7, 0, 16128, 1);         // largest request round a two-block loop
    map_range(7, 100, 16128, 1);       // the most extents one request can give
    map_range(7, 2097151, 10, 0);      // the loop outlasts the depot size
    map_range(4095, 0, 5, 0);
    map_range(4095, 511, 8191, 0);
    heads.push_back(0);
    head_len.push_back(3);
    heads.push_back(7);
    head_len.push_back(2);
    heads.push_back(4095);
    head_len.push_back(1);

    for (p = 0; p < 9; p++) begin
      v = used_plan[p];
      if (v < 0) v = $urandom_range(2, BCEM_DEPOT_ENTRIES - 1);
      set_depot_used(v);
      phase_start = items_sent;
      while (items_sent - phase_start < 28) begin
        if ($urandom_range(0, 3) == 0) begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
          build_chain(n);
        end else begin
          h = $urandom_range(0, heads.size() - 1);
          start = heads[h];
          blocks = head_len[h];
          r = $urandom_range(0, 99);
          if (r < 8) begin
            start = written_list[$urandom_range(0, written_list.size() - 1)];
            blocks = 4;
          end else if (r < 14 && used_now < BCEM_DEPOT_ENTRIES) begin
            start = $urandom_range(used_now, BCEM_DEPOT_ENTRIES - 1);
          end
          uni = $urandom_range(0, 1);
          if ($urandom_range(0, 9) == 0) off = $urandom_range(0, 2097151);
          else off = $urandom_range(0, blocks * BCEM_BLOCK_SIZE - 1);
          r = $urandom_range(0, 99);
          if (r < 6) begin
            chars = 0;
          end else if (r < 12) begin
            chars = $urandom_range(BCEM_MAX_CHARS, 16383);
          end else if (r < 20) begin
            chars = $urandom_range(0, 16383);
          end else begin
            lim = (blocks * BCEM_BLOCK_SIZE + 700) >> uni;
            if (lim > 16383) lim = 16383;
            chars = $urandom_range(1, lim);
          end
          map_range(start, off, chars, uni);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb_top: %0d items sent, %0d of them map requests, over %0d depot_used settings",
             items_sent, maps_sent, settings_done);
    $display("tb_top: %0d extents and closing results compared, %0d mismatches",
             checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[block_chain_extent_mapper_unit.f]
src/bcem_pkg.sv
src/bcem_depot.sv
src/block_chain_extent_mapper_unit.sv
verif/bcem_extent_checker.sv
verif/tb_top.sv
